@@ rtl/core/button_debounce_click_longpress_unit_assert.svh @@
// Assertion macros shared by the button debounce checker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef BUTTON_DEBOUNCE_CLICK_LONGPRESS_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_LONGPRESS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("button debounce check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("button debounce check failed");

`endif

@@ rtl/core/bdcl_pkg.sv @@
// Package for the button debounce unit: event codes, register indexes,
// per-channel state type and the poll evaluation function. No dependencies.
`timescale 1ns / 1ps

package bdcl_pkg;

  localparam int BDCL_CHANNELS = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd10;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd600;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_LONG  = 2'd1,
    EV_CLICK = 2'd2
  } event_e;

  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic              debounced_level;
    logic              previous_raw;
    logic [TIME_W-1:0] raw_change_time;
    logic [TIME_W-1:0] press_start_time;
    logic              long_done;
  } chan_state_t;

  typedef struct packed {
    chan_state_t next_state;
    event_e      ev;
  } poll_res_t;

  // One poll of one channel: new state and the event it reports.
  function automatic poll_res_t poll_eval(chan_state_t st, logic raw,
                                          logic [TIME_W-1:0] now, cfg_t cfg);
    poll_res_t         res;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_press;
    res.next_state = st;
    res.ev = EV_NONE;
    if (raw != st.previous_raw) begin
      res.next_state.previous_raw = raw;
      res.next_state.raw_change_time = now;
    end
    held = now - res.next_state.raw_change_time;
    since_press = now - st.press_start_time;
    if ((held < TIME_W'(cfg.debounce_time)) || (raw == st.debounced_level)) begin
      // No debounced change: check for the long press.
      if (st.debounced_level && !st.long_done &&
          (since_press >= TIME_W'(cfg.long_press_time))) begin
        res.next_state.long_done = 1'b1;
        res.ev = EV_LONG;
      end
    end else begin
      res.next_state.debounced_level = raw;
      if (raw) begin
        res.next_state.press_start_time = now;
        res.next_state.long_done = 1'b0;
      end else if (!st.long_done) begin
        res.ev = EV_CLICK;
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/bdcl_ifs.sv @@
// Valid/ready channel interfaces for polls in and events out.
// Depends on bdcl_pkg for the time width.
`timescale 1ns / 1ps

interface bdcl_poll_if import bdcl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              channel;
  logic              pressed;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, output channel, output pressed, output now_time,
                  input ready);
  modport sink (input valid, input channel, input pressed, input now_time,
                output ready);
endinterface

interface bdcl_event_if ();
  logic       valid;
  logic       ready;
  logic [1:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink (input valid, input event_res, output ready);
endinterface

@@ rtl/core/bdcl_cfg_regs.sv @@
// APB-style configuration registers: debounce time and long-press time.
// Depends on bdcl_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps

module bdcl_cfg_regs import bdcl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign idx = reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:   cfg_d.debounce_time = pwdata[CFG_W-1:0];
        REG_LONG_PRESS: cfg_d.long_press_time = pwdata[CFG_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time <= DEBOUNCE_RESET;
      cfg_q.long_press_time <= LONG_PRESS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      REG_DEBOUNCE:   prdata = APB_DATA_W'(cfg_q.debounce_time);
      REG_LONG_PRESS: prdata = APB_DATA_W'(cfg_q.long_press_time);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/bdcl_state_bank.sv @@
// Per-channel button state registers with one read and one write port.
// Depends on bdcl_pkg for the channel state struct.
`timescale 1ns / 1ps

module bdcl_state_bank import bdcl_pkg::*; #(
  parameter int CHANNELS = BDCL_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_chan_i,
  output logic        rd_ok_o,
  output chan_state_t rd_state_o,
  input  logic        wr_en_i,
  input  logic        wr_chan_i,
  input  chan_state_t wr_state_i
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  chan_state_t     state_q [CHANNELS];
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  assign rd_idx = IDX_W'(rd_chan_i);
  assign wr_idx = IDX_W'(wr_chan_i);

  // Polls for channels that do not exist are ignored.
  assign rd_ok_o = int'(rd_chan_i) < CHANNELS;
  assign rd_state_o = rd_ok_o ? state_q[rd_idx] : '0;

  // State update, one channel per accepted poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      state_q[wr_idx] <= wr_state_i;
    end
  end

endmodule

@@ rtl/core/button_debounce_click_longpress_unit.sv @@
// Button debounce unit with click and long-press events, top level.
// Depends on bdcl_pkg, bdcl_ifs, bdcl_cfg_regs and bdcl_state_bank.
//
// Usage: poll_i carries one word per poll (channel, raw pressed level,
// millisecond timestamp); event_o returns exactly one word per poll with
// event_res 0 (none), 1 (long press) or 2 (click), in poll order.
// A poll is taken into an input register, evaluated against the channel's
// state by short compare logic and stored in the result register.
// Throughput: one poll per cycle while event_o is ready; the channel state
// is written as a poll moves to the result register, so the next poll of
// the same channel sees it.
// When event_o stalls, one more poll is still taken into the input register;
// after that poll_i.ready drops until the result word is taken.
// Reset clears all channel state, sets debounce time to 10 ms and long-press
// time to 600 ms, and empties both registers. Configuration must be written over
// the APB-style port only while no poll is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module button_debounce_click_longpress_unit import bdcl_pkg::*; #(
  parameter int CHANNELS = BDCL_CHANNELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bdcl_poll_if.sink             poll_i,
  bdcl_event_if.source          event_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t        cfg;
  chan_state_t rd_state;
  logic        rd_ok;
  poll_res_t   eval;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_chan_q;
  logic              s1_pressed_q;
  logic [TIME_W-1:0] s1_now_q;
  logic              out_valid_q, out_valid_d;
  event_e            out_event_q;
  logic              in_accept;
  logic              advance;

  bdcl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdcl_state_bank #(
    .CHANNELS (CHANNELS)
  ) u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_chan_i  (s1_chan_q),
    .rd_ok_o    (rd_ok),
    .rd_state_o (rd_state),
    .wr_en_i    (advance && rd_ok),
    .wr_chan_i  (s1_chan_q),
    .wr_state_i (eval.next_state)
  );

  // Handshake: the input register moves on when the result register frees.
  assign advance = s1_valid_q && (!out_valid_q || event_o.ready);
  assign poll_i.ready = !s1_valid_q || advance;
  assign in_accept = poll_i.valid && poll_i.ready;

  // Evaluate the registered poll.
  assign eval = poll_eval(rd_state, s1_pressed_q, s1_now_q, cfg);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (event_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_chan_q <= poll_i.channel;
      s1_pressed_q <= poll_i.pressed;
      s1_now_q <= poll_i.now_time;
    end
    if (advance) begin
      out_event_q <= rd_ok ? eval.ev : EV_NONE;
    end
  end

  assign event_o.valid = out_valid_q;
  assign event_o.event_res = out_event_q;

endmodule

@@ rtl/core/bdcl_checker.sv @@
// Port-level checker for the button debounce unit, bound to the top level.
// Depends on button_debounce_click_longpress_unit_assert.svh for the macros.
`timescale 1ns / 1ps
`include "button_debounce_click_longpress_unit_assert.svh"

module bdcl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_event_i
);

  // Event codes stay within none, long press and click.
  `BDCL_ASSERT_SAME(a_event_code, clk_i, rst_ni, out_valid_i, out_event_i != 2'd3)

  // A stalled result word is held.
  `BDCL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A fresh result follows a poll that was accepted and passed through the input register.
  `BDCL_ASSERT_SAME(a_out_cause, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

  // With the result register empty, polls are always taken.
  `BDCL_ASSERT_SAME(a_ready_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind button_debounce_click_longpress_unit bdcl_checker u_bdcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (poll_i.valid),
  .in_ready_i  (poll_i.ready),
  .out_valid_i (event_o.valid),
  .out_ready_i (event_o.ready),
  .out_event_i (event_o.event_res)
);
